>>> hw/rtl/wscg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscg_pkg: shared types and constants for the channel symbol generator
// encoder polynomials, frame geometry, sync vector and register codes
// ----------------------------------------------------------------------------
package wscg_pkg;

  localparam int unsigned CALL_W        = 28;
  localparam int unsigned GRID_W        = 22;
  localparam int unsigned MSG_W         = CALL_W + GRID_W;
  localparam int unsigned ENC_W         = 32;
  localparam int unsigned FRAME_SYMBOLS = 162;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned TONE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 28;

  localparam logic [ENC_W-1:0] GEN_A = 32'hf2d0_5351;
  localparam logic [ENC_W-1:0] GEN_B = 32'he461_3c47;

  localparam logic [IDX_W-1:0] LAST_INDEX   = IDX_W'(FRAME_SYMBOLS - 1);
  localparam logic [IDX_W-1:0] FRAME_LIMIT  = IDX_W'(FRAME_SYMBOLS);
  localparam logic [IDX_W-1:0] LAST_WALK    = '1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CALL_WORD       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_POWER_WORD = 1'b1;

  // sync bit per symbol, index 0 leftmost
  localparam logic [0:FRAME_SYMBOLS-1] SYNC_VEC = {
    20'b11000000100011100010, 20'b01011110000000100101,
    20'b00000010110011010001, 20'b10100001101010101001,
    20'b00101100011010100010, 20'b00001001001110110011,
    20'b01000111000001010011, 20'b00000001101011000110,
    2'b00};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_EMIT
  } state_e;

  function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] val);
    logic [IDX_W-1:0] res;
    for (int k = 0; k < int'(IDX_W); k++) begin
      res[k] = val[IDX_W-1-k];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/wscg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscg channel interfaces
// valid/ready channels for config writes, symbol requests and symbols out
// ----------------------------------------------------------------------------
interface wscg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wscg_pkg::CFG_IDX_W-1:0]      index;
  logic [wscg_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface wscg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, restart, input ready);
  modport sink   (input valid, restart, output ready);
endinterface

interface wscg_out_if;
  logic                            valid;
  logic                            ready;
  logic [wscg_pkg::TONE_W-1:0]     tone;
  logic [wscg_pkg::IDX_W-1:0]      symbol_index;
  logic                            last_symbol;
  modport source (output valid, tone, symbol_index, last_symbol, input ready);
  modport sink   (input valid, tone, symbol_index, last_symbol, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/wscg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscg_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module wscg_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 162,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wspr_channel_symbol_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wspr channel symbol generator core
// k=32 rate 1/2 convolutional encoder, bit-reversal interleaver, 4-fsk mapper
// ----------------------------------------------------------------------------
//
// channel   dir   payload                               transfer meaning
// cfg_if    in    index, data                           write one message word
// req_if    in    restart                               restart frame or next tick
// sym_if    out   tone, symbol_index, last_symbol       one channel symbol
//
// restart: walk over all 256 addresses, one coded bit from the shared masked-parity
// unit per address that bit-reverses into the frame; the last step fetches symbol 0
// plain tick: frame ram read on the transfer edge; EMIT loads the output when free
// reset clears config words, sequencer, frame pointer and output valid;
// the frame ram holds no reset and is fully rewritten by every restart
// requests wait while a frame is built or a symbol waits for the output register
//
module wspr_channel_symbol_generator_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  wscg_cfg_if.sink       cfg_if,
  wscg_in_if.sink        req_if,
  wscg_out_if.source     sym_if
);

  localparam int unsigned IDX_W = wscg_pkg::IDX_W;
  localparam int unsigned ENC_W = wscg_pkg::ENC_W;
  localparam int unsigned MSG_W = wscg_pkg::MSG_W;

  // config words
  logic [wscg_pkg::CALL_W-1:0] call_q;
  logic [wscg_pkg::GRID_W-1:0] grid_q;

  // sequencer and frame pointer
  wscg_pkg::state_e state_q, state_d;
  logic             active_q, active_d;
  logic [IDX_W-1:0] next_idx_q, next_idx_d;

  // encoder walk
  logic [IDX_W-1:0] walk_q, walk_d;
  logic             p_odd_q, p_odd_d;
  logic [ENC_W-1:0] enc_q, enc_d;
  logic [MSG_W-1:0] msg_q, msg_d;

  // output register
  logic                          out_vld_q, out_vld_d;
  logic [wscg_pkg::TONE_W-1:0]   tone_q;
  logic [IDX_W-1:0]              sym_idx_q;
  logic                          last_q;

  logic             req_xfer;
  logic             cfg_xfer;
  logic             out_load;
  logic             walk_done;
  logic [IDX_W-1:0] perm_idx;
  logic             perm_hit;
  logic             coded_bit;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic             ram_rd_bit;

  assign cfg_if.ready = 1'b1;
  assign cfg_xfer     = cfg_if.valid & cfg_if.ready;
  assign req_xfer     = req_if.valid & req_if.ready;

  // interleaver address and the shared masked-parity unit
  assign perm_idx  = wscg_pkg::bit_rev(walk_q);
  assign perm_hit  = (perm_idx < wscg_pkg::FRAME_LIMIT);
  assign coded_bit = ^(enc_q & (p_odd_q ? wscg_pkg::GEN_B : wscg_pkg::GEN_A));
  assign walk_done = (walk_q == wscg_pkg::LAST_WALK);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wscg_pkg::ST_IDLE: begin
        if (req_xfer) begin
          if (req_if.restart) begin
            state_d = wscg_pkg::ST_BUILD;
          end else if (active_q) begin
            state_d = wscg_pkg::ST_EMIT;
          end
        end
      end
      wscg_pkg::ST_BUILD: begin
        if (walk_done) begin
          state_d = wscg_pkg::ST_EMIT;
        end
      end
      wscg_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = wscg_pkg::ST_IDLE;
        end
      end
      default: state_d = wscg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_if.ready = 1'b0;
    ram_wr_en    = 1'b0;
    ram_rd_en    = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      wscg_pkg::ST_IDLE: begin
        req_if.ready = 1'b1;
        ram_rd_en    = req_xfer & ~req_if.restart & active_q;
      end
      wscg_pkg::ST_BUILD: begin
        ram_wr_en = perm_hit;
        // fetch symbol 0 on the final walk step
        ram_rd_en = walk_done;
      end
      wscg_pkg::ST_EMIT: begin
        out_load = ~out_vld_q | sym_if.ready;
      end
      default: begin
        req_if.ready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    active_d   = active_q;
    next_idx_d = next_idx_q;
    walk_d     = walk_q;
    p_odd_d    = p_odd_q;
    enc_d      = enc_q;
    msg_d      = msg_q;
    out_vld_d  = out_load | (out_vld_q & ~sym_if.ready);

    if (req_xfer && req_if.restart) begin
      // first message bit enters the encoder right away
      active_d   = 1'b1;
      next_idx_d = '0;
      walk_d     = '0;
      p_odd_d    = 1'b0;
      enc_d      = {{(ENC_W-1){1'b0}}, call_q[wscg_pkg::CALL_W-1]};
      msg_d      = {call_q[wscg_pkg::CALL_W-2:0], grid_q, 1'b0};
    end else if (state_q == wscg_pkg::ST_BUILD) begin
      walk_d = walk_q + 1'b1;
      if (perm_hit) begin
        p_odd_d = ~p_odd_q;
        // shift in the next message bit after both parities are taken
        if (p_odd_q) begin
          enc_d = {enc_q[ENC_W-2:0], msg_q[MSG_W-1]};
          msg_d = {msg_q[MSG_W-2:0], 1'b0};
        end
      end
    end

    if (out_load) begin
      if (next_idx_q == wscg_pkg::LAST_INDEX) begin
        next_idx_d = '0;
        active_d   = 1'b0;
      end else begin
        next_idx_d = next_idx_q + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wscg_pkg::ST_IDLE;
      active_q   <= 1'b0;
      next_idx_q <= '0;
      walk_q     <= '0;
      p_odd_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      call_q     <= '0;
      grid_q     <= '0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      next_idx_q <= next_idx_d;
      walk_q     <= walk_d;
      p_odd_q    <= p_odd_d;
      out_vld_q  <= out_vld_d;
      if (cfg_xfer) begin
        case (cfg_if.index)
          wscg_pkg::REG_CALL_WORD: begin
            call_q <= cfg_if.data[wscg_pkg::CALL_W-1:0];
          end
          wscg_pkg::REG_GRID_POWER_WORD: begin
            grid_q <= cfg_if.data[wscg_pkg::GRID_W-1:0];
          end
          default: begin
            call_q <= call_q;
          end
        endcase
      end
    end
  end

  // encoder shift registers and output payload
  always_ff @(posedge clk_i) begin
    enc_q <= enc_d;
    msg_q <= msg_d;
    if (out_load) begin
      tone_q    <= {ram_rd_bit, wscg_pkg::SYNC_VEC[next_idx_q]};
      sym_idx_q <= next_idx_q;
      last_q    <= (next_idx_q == wscg_pkg::LAST_INDEX);
    end
  end

  // interleaved coded bits
  wscg_ram #(
    .WIDTH (1),
    .DEPTH (wscg_pkg::FRAME_SYMBOLS)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (perm_idx),
    .wr_data_i (coded_bit),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (next_idx_d),
    .rd_data_o (ram_rd_bit)
  );

  assign sym_if.valid        = out_vld_q;
  assign sym_if.tone         = tone_q;
  assign sym_if.symbol_index = sym_idx_q;
  assign sym_if.last_symbol  = last_q;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for wspr_channel_symbol_generator_core
// drives packed message words, restart and tick requests over valid/ready
// channels, predicts every channel symbol from its own encoder model and
// compares each symbol transfer field by field against the expected stream
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAME_LEN       = 162;
  localparam int SETTLE_CYCLES   = 300;   // quiet time after all owed symbols are delivered
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TARGET_SYMBOLS  = 1000;

  typedef logic [wscg_pkg::CFG_IDX_W-1:0]  reg_index_t;
  typedef logic [wscg_pkg::CFG_DATA_W-1:0] reg_data_t;

  // one channel symbol as it leaves the block
  typedef struct packed {
    logic [wscg_pkg::TONE_W-1:0] tone;
    logic [wscg_pkg::IDX_W-1:0]  index;
    logic                        last;
  } symbol_t;

  // --------------------------------------------------------------------------
  // symbol scoreboard: encoder model plus the queue of symbols still owed
  // --------------------------------------------------------------------------
  class symbol_scoreboard;
    localparam logic [31:0] POLY_FIRST  = 32'hf2d0_5351;
    localparam logic [31:0] POLY_SECOND = 32'he461_3c47;
    localparam int CALL_BITS = 28;
    localparam int MSG_BITS  = 50;
    // sync bit per symbol, symbol 0 leftmost
    localparam logic [0:FRAME_LEN-1] SYNC_PATTERN = {
      20'b11000000100011100010, 20'b01011110000000100101,
      20'b00000010110011010001, 20'b10100001101010101001,
      20'b00101100011010100010, 20'b00001001001110110011,
      20'b01000111000001010011, 20'b00000001101011000110,
      2'b00};

    logic [CALL_BITS-1:0]          call_word;
    logic [MSG_BITS-CALL_BITS-1:0] grid_word;
    logic [0:FRAME_LEN-1]          frame_bits;
    logic [wscg_pkg::IDX_W-1:0]    next_symbol;
    bit                            frame_loaded;
    symbol_t                       pending[$];
    int unsigned errors, requests, restarts, reg_writes;
    int unsigned symbols_expected, symbols_checked, frames_done;

    function new();
      call_word        = '0;
      grid_word        = '0;
      frame_bits       = '0;
      next_symbol      = '0;
      frame_loaded     = 1'b0;
      errors           = 0;
      requests         = 0;
      restarts         = 0;
      reg_writes       = 0;
      symbols_expected = 0;
      symbols_checked  = 0;
      frames_done      = 0;
    endfunction

    function void write_word(reg_index_t idx, reg_data_t data);
      reg_writes++;
      if (idx == wscg_pkg::REG_CALL_WORD) begin
        call_word = data[CALL_BITS-1:0];
      end else begin
        grid_word = data[MSG_BITS-CALL_BITS-1:0];
      end
    endfunction

    // message bit k, msb first, zero tail past the 50 message bits
    function logic message_bit(int k);
      if (k < CALL_BITS) return call_word[CALL_BITS-1-k];
      if (k < MSG_BITS) return grid_word[MSG_BITS-1-k];
      return 1'b0;
    endfunction

    function void encode_frame();
      logic [31:0]          shreg;
      logic [0:FRAME_LEN-1] coded;
      logic [7:0]           addr;
      logic [7:0]           rev;
      int                   n;
      int                   k;
      int                   p;
      shreg = '0;
      n     = 0;
      k     = 0;
      while (n < FRAME_LEN) begin
        shreg      = {shreg[30:0], message_bit(k)};
        coded[n]   = ^(shreg & POLY_FIRST);
        coded[n+1] = ^(shreg & POLY_SECOND);
        n += 2;
        k++;
      end
      // bit-reversed addresses beyond the frame are skipped
      p = 0;
      for (int i = 0; i < 256 && p < FRAME_LEN; i++) begin
        addr = i[7:0];
        rev  = {addr[0], addr[1], addr[2], addr[3], addr[4], addr[5], addr[6], addr[7]};
        if (rev < FRAME_LEN) begin
          frame_bits[rev] = coded[p];
          p++;
        end
      end
    endfunction

    function void note_request(bit restart);
      symbol_t sym;
      requests++;
      if (restart) begin
        restarts++;
        encode_frame();
        next_symbol  = '0;
        frame_loaded = 1'b1;
      end
      if (!frame_loaded) return;
      sym.tone  = {frame_bits[next_symbol], SYNC_PATTERN[next_symbol]};
      sym.index = next_symbol;
      sym.last  = (next_symbol == FRAME_LEN - 1);
      pending.push_back(sym);
      symbols_expected++;
      next_symbol++;
      if (next_symbol == FRAME_LEN) begin
        next_symbol  = '0;
        frame_loaded = 1'b0;
      end
    endfunction

    function void check_symbol(symbol_t got);
      symbol_t want;
      symbols_checked++;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected symbol: index %0d tone %0d last %0d",
               got.index, got.tone, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.tone !== want.tone) begin
        errors++;
        $error("tone mismatch: expected %0d actual %0d", want.tone, got.tone);
      end
      if (got.index !== want.index) begin
        errors++;
        $error("symbol_index mismatch: expected %0d actual %0d", want.index, got.index);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last_symbol mismatch: expected %0d actual %0d", want.last, got.last);
      end
      if (want.last) frames_done++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, channels, block under test
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  wscg_cfg_if cfg_bus ();
  wscg_in_if  req_bus ();
  wscg_out_if sym_bus ();

  wspr_channel_symbol_generator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_bus),
    .req_if (req_bus),
    .sym_if (sym_bus)
  );

  symbol_scoreboard scoreboard;

  // shared between the request and symbol sides
  bit steady_flow;    // no random gaps or stalls on either side while set; a pending hold-off still applies
  bit hold_pending;   // symbol side holds ready low for a long stretch next
  int unsigned holds_done;

  // --------------------------------------------------------------------------
  // request side: drive at the falling edge, a transfer happens at the rising
  // edge where valid and ready are both high
  // --------------------------------------------------------------------------
  task automatic send_request(bit restart);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_bus.valid   <= 1'b1;
    req_bus.restart <= restart;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    scoreboard.note_request(restart);
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_request(1'b0);
  endtask

  task automatic write_register(reg_index_t idx, reg_data_t data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    scoreboard.write_word(idx, data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // all owed symbols delivered, then room for a tick that yields nothing
  task automatic wait_idle();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (scoreboard.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // message words: extremes, alternating patterns or random bits
  function automatic reg_data_t pick_word();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 28'h555_5555;
      3:       return 28'haaa_aaaa;
      default: return reg_data_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // symbol side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : symbol_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        stall        = HOLD_OFF_CYCLES;
        hold_pending = 1'b0;
        holds_done++;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 3);
      end
      repeat (stall) begin
        @(negedge clk_i);
        sym_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      sym_bus.ready <= 1'b1;
      do @(posedge clk_i); while (sym_bus.valid !== 1'b1);
      scoreboard.check_symbol({sym_bus.tone, sym_bus.symbol_index, sym_bus.last_symbol});
    end
  end

  // --------------------------------------------------------------------------
  // stimulus: directed corner cases, then random frame sequences
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int seq;
    int kind;
    scoreboard      = new();
    rst_ni          = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = wscg_pkg::REG_CALL_WORD;
    cfg_bus.data    = '0;
    req_bus.valid   = 1'b0;
    req_bus.restart = 1'b0;
    sym_bus.ready   = 1'b0;
    steady_flow     = 1'b0;
    hold_pending    = 1'b0;
    holds_done      = 0;
    seq             = 0;
    kind            = 0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ticks with no frame loaded produce nothing
    send_ticks(2);
    // all-zero message straight out of reset: tones equal the sync pattern
    send_request(1'b1);
    send_ticks(3);
    wait_idle();
    // all-ones words, upper data bits of the grid word land beyond its width
    write_register(wscg_pkg::REG_CALL_WORD, '1);
    write_register(wscg_pkg::REG_GRID_POWER_WORD, '1);
    // stored frame keeps going until the next restart
    send_ticks(2);
    send_request(1'b1);
    send_ticks(4);
    // restart in the middle of a frame starts over at symbol 0
    send_request(1'b1);
    send_ticks(2);
    wait_idle();
    write_register(wscg_pkg::REG_CALL_WORD, 28'h555_5555);
    write_register(wscg_pkg::REG_GRID_POWER_WORD, 28'haaa_aaaa);
    send_request(1'b1);
    send_ticks(1);

    // first random frame runs into a long output hold-off so the block backs up
    hold_pending = 1'b1;
    while (scoreboard.symbols_expected < TARGET_SYMBOLS) begin
      if (seq != 0 && $urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 2))
          0: begin
            write_register(wscg_pkg::REG_CALL_WORD, pick_word());
            write_register(wscg_pkg::REG_GRID_POWER_WORD, pick_word());
          end
          1:       write_register(wscg_pkg::REG_CALL_WORD, pick_word());
          default: write_register(wscg_pkg::REG_GRID_POWER_WORD, pick_word());
        endcase
      end
      steady_flow = ($urandom_range(0, 3) == 0);
      kind        = (seq == 0) ? 9 : $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: stray ticks and the odd restart
        repeat ($urandom_range(1, 6)) send_request($urandom_range(0, 5) == 0);
      end else if (kind <= 2 && scoreboard.frame_loaded) begin
        // finish a partly sent frame, maybe past its end
        send_ticks(FRAME_LEN - int'(scoreboard.next_symbol) + $urandom_range(0, 2));
      end else if (kind <= 3) begin
        // broken frame, cut short by whatever comes next
        send_request(1'b1);
        send_ticks($urandom_range(1, FRAME_LEN - 2));
      end else begin
        // whole frame, sometimes a tick or two beyond the last symbol
        send_request(1'b1);
        send_ticks(FRAME_LEN - 1 + $urandom_range(0, 2));
      end
      seq++;
    end

    // drain and leave time for a late or stray symbol to show up
    steady_flow = 1'b0;
    wait_idle();

    $display("run: %0d requests, %0d restarts, %0d register writes, %0d long hold-off",
             scoreboard.requests, scoreboard.restarts, scoreboard.reg_writes, holds_done);
    $display("run: %0d symbols checked, %0d complete frames",
             scoreboard.symbols_checked, scoreboard.frames_done);
    if (scoreboard.errors == 0 && scoreboard.pending.size() == 0) begin
      $display("PASS wspr_channel_symbol_generator_core");
    end else begin
      $display("FAIL wspr_channel_symbol_generator_core");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("FAIL wspr_channel_symbol_generator_core");
    $finish;
  end

endmodule
